// ===== sv/assert_macros.svh =====
// Assertion macros shared by the mean-absolute-gradient window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MAG_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MAG_ASSERT(lbl, prop, msg)
`define MAG_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== sv/mag_pkg.sv =====
// Types, constants and register codes of the mean-absolute-gradient window.
`timescale 1ns / 1ps
package mag_pkg;

  localparam int PIX_W          = 8;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_WINDOW     = 32;
  localparam int RING_W         = $clog2(MAX_WINDOW);
  localparam int WIN_W          = 6;
  localparam int SUM_W          = $clog2(MAX_WINDOW * ((1 << PIX_W) - 1) + 1);
  localparam int FRAC_W         = 8;
  localparam int DVD_W          = SUM_W + FRAC_W;
  localparam int MEAN_W         = 16;
  localparam int POS_W          = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 11;
  localparam int IN_TDATA_W     = ((PIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = ((MEAN_W + 2 * POS_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = CFG_IDX_W'(3);

  localparam logic DIR_HORIZ = 1'b0;
  localparam logic DIR_VERT  = 1'b1;

  localparam logic [WIN_W-1:0]      WINDOW_RST = WIN_W'(4);
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = CFG_DATA_W'(480);

  typedef struct packed {
    logic [WIN_W-1:0] divisor;
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } job_t;

endpackage

// ===== sv/mag_core.sv =====
// Pixel front end: configuration, raster counters and read-modify-write of the line stores.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mag_core
  import mag_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pix_valid_i,
  output logic                  pix_ready_o,
  input  logic [PIX_W-1:0]      pix_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output job_t                  job_o
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int HA_W       = COL_W + RING_W;
  localparam int HIST_DEPTH = MAX_WIDTH * MAX_WINDOW;
  localparam int CM_W       = SUM_W + PIX_W;
  localparam int PIX_MAX    = (1 << PIX_W) - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_HAND = 2'd2;

  logic                  dir_q;
  logic [WIN_W-1:0]      win_q;
  logic [CFG_DATA_W-1:0] wid_q;
  logic [CFG_DATA_W-1:0] hgt_q;

  logic [1:0]       state_q, state_d;
  logic [COL_W-1:0] col_cnt_q;
  logic [ROW_W-1:0] row_cnt_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [PIX_W-1:0] pix_q;
  logic             last_q;
  logic [PIX_W-1:0] prev_q;
  logic [SUM_W-1:0] row_sum_q;
  job_t             job_q;

  logic [PIX_W-1:0] hist_mem [HIST_DEPTH];
  logic [CM_W-1:0]  col_mem [MAX_WIDTH];
  logic [PIX_W-1:0] hist_rd_q;
  logic [CM_W-1:0]  cm_rd_q;

  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic [WIN_W-1:0] s_w;
  logic             accept;
  logic             at_last;
  logic [RING_W-1:0] rd_ring;
  logic [HA_W-1:0]   hist_rd_addr;

  int               pos_c;
  logic             active;
  logic             first;
  logic             emit;
  logic [PIX_W-1:0] ref_pix;
  logic [PIX_W-1:0] diff;
  logic [SUM_W-1:0] old_sum;
  logic [SUM_W:0]   acc;
  logic [SUM_W-1:0] new_sum;
  logic [RING_W-1:0] wr_ring;
  logic [HA_W-1:0]   hist_wr_addr;
  logic [CM_W-1:0]   cm_wr_data;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_col;
  logic              calc;

  always_comb begin
    int wc;
    int hc;
    wc = int'(wid_q);
    hc = int'(hgt_q);
    if (wc < 2) begin
      wc = 2;
    end else if (wc > MAX_WIDTH) begin
      wc = MAX_WIDTH;
    end
    if (hc < 2) begin
      hc = 2;
    end else if (hc > MAX_HEIGHT) begin
      hc = MAX_HEIGHT;
    end
    last_col = COL_W'(wc - 1);
    last_row = ROW_W'(hc - 1);
    if (win_q == '0) begin
      s_w = WIN_W'(1);
    end else if (int'(win_q) > MAX_WINDOW) begin
      s_w = WIN_W'(MAX_WINDOW);
    end else begin
      s_w = win_q;
    end
  end

  assign pix_ready_o = (state_q == ST_IDLE);
  assign accept      = pix_valid_i && pix_ready_o;
  assign at_last     = (col_cnt_q == last_col) && (row_cnt_q == last_row);
  assign calc        = (state_q == ST_CALC);

  always_comb begin
    int pos_n;
    pos_n = (dir_q == DIR_VERT) ? int'(row_cnt_q) : int'(col_cnt_q);
    rd_ring = RING_W'(pos_n - 1 - int'(s_w));
    hist_rd_addr = {((dir_q == DIR_VERT) ? col_cnt_q : COL_W'(0)), rd_ring};
  end

  always_comb begin
    pos_c   = (dir_q == DIR_VERT) ? int'(row_q) : int'(col_q);
    active  = (pos_c >= 1);
    first   = (pos_c == 1);
    emit    = active && (pos_c >= int'(s_w) + 1);
    ref_pix = (dir_q == DIR_VERT) ? cm_rd_q[PIX_W-1:0] : prev_q;
    diff    = (pix_q > ref_pix) ? (pix_q - ref_pix) : (ref_pix - pix_q);
    old_sum = (dir_q == DIR_VERT) ? cm_rd_q[CM_W-1:PIX_W] : row_sum_q;
    acc     = {1'b0, old_sum} + (SUM_W + 1)'(diff);
    if (emit) begin
      acc = acc - (SUM_W + 1)'(hist_rd_q);
    end
    new_sum = first ? SUM_W'(diff) : acc[SUM_W-1:0];
    wr_ring = RING_W'(pos_c - 1);
    hist_wr_addr = {((dir_q == DIR_VERT) ? col_q : COL_W'(0)), wr_ring};
    cm_wr_data = {(((dir_q == DIR_VERT) && active) ? new_sum : cm_rd_q[CM_W-1:PIX_W]), pix_q};
    if (dir_q == DIR_VERT) begin
      out_row = POS_W'(int'(row_q) - 1 - int'(s_w));
      out_col = POS_W'(int'(col_q));
    end else begin
      out_row = POS_W'(int'(row_q));
      out_col = POS_W'(int'(col_q) - 1 - int'(s_w));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_rd_q <= hist_mem[hist_rd_addr];
    end
    if (calc && active) begin
      hist_mem[hist_wr_addr] <= diff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cm_rd_q <= col_mem[col_cnt_q];
    end
    if (calc) begin
      col_mem[col_q] <= cm_wr_data;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = emit ? ST_HAND : ST_IDLE;
      end
      ST_HAND: begin
        if (job_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= DIR_HORIZ;
      win_q     <= WINDOW_RST;
      wid_q     <= WIDTH_RST;
      hgt_q     <= HEIGHT_RST;
      state_q   <= ST_IDLE;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      prev_q    <= '0;
      row_sum_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_DIRECTION: dir_q <= cfg_data_i[0];
          REG_WINDOW:    win_q <= cfg_data_i[WIN_W-1:0];
          REG_WIDTH:     wid_q <= cfg_data_i;
          REG_HEIGHT:    hgt_q <= cfg_data_i;
          default:       dir_q <= dir_q;
        endcase
        col_cnt_q <= '0;
        row_cnt_q <= '0;
        prev_q    <= '0;
        row_sum_q <= '0;
      end else begin
        if (accept) begin
          if (col_cnt_q == last_col) begin
            col_cnt_q <= '0;
            row_cnt_q <= (row_cnt_q == last_row) ? '0 : row_cnt_q + ROW_W'(1);
          end else begin
            col_cnt_q <= col_cnt_q + COL_W'(1);
          end
        end
        if (calc) begin
          prev_q <= pix_q;
          if ((dir_q == DIR_HORIZ) && active) begin
            row_sum_q <= new_sum;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q  <= col_cnt_q;
      row_q  <= row_cnt_q;
      pix_q  <= pix_i;
      last_q <= at_last;
    end
    if (calc && emit) begin
      job_q.divisor <= s_w;
      job_q.sum     <= new_sum;
      job_q.row     <= out_row;
      job_q.col     <= out_col;
      job_q.last    <= last_q;
    end
  end

  assign job_valid_o = (state_q == ST_HAND);
  assign job_o       = job_q;

  `MAG_ASSERT(a_job_hold, job_valid_o && !job_ready_i |=> job_valid_o && $stable(job_o), "job changed while waiting for the divider")
  `MAG_ASSERT(a_pos_range, (state_q == ST_IDLE) |-> (col_cnt_q <= last_col) && (row_cnt_q <= last_row), "raster counter beyond frame")
  `MAG_ASSERT(a_sum_bound, calc && active |-> int'(new_sum) <= int'(s_w) * PIX_MAX, "window sum exceeds window bound")

endmodule

// ===== sv/mag_div.sv =====
// Radix-2 restoring divider for the window mean with the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mag_div
  import mag_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  job_t                   job_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam int PAD_W = OUT_TDATA_W - MEAN_W - 2 * POS_W;

  localparam logic [1:0] D_FREE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_HOLD = 2'd2;

  logic [1:0]       st_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIN_W-1:0] rem_q;
  logic [DVD_W-1:0] dvd_q;
  logic [WIN_W-1:0] div_q;
  logic [POS_W-1:0] row_q;
  logic [POS_W-1:0] col_q;
  logic             last_q;

  logic [WIN_W:0]   trial;
  logic [WIN_W:0]   diff;
  logic             ge;
  logic             start;

  assign job_ready_o = (st_q == D_FREE);
  assign start       = job_valid_i && job_ready_o;
  assign trial       = {rem_q, dvd_q[DVD_W-1]};
  assign ge          = (trial >= {1'b0, div_q});
  assign diff        = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= D_FREE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        D_FREE: begin
          if (start) begin
            st_q  <= D_RUN;
            cnt_q <= CNT_W'(DVD_W);
          end
        end
        D_RUN: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            st_q <= D_HOLD;
          end
        end
        D_HOLD: begin
          if (m_axis_tready) begin
            st_q <= D_FREE;
          end
        end
        default: st_q <= D_FREE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      rem_q  <= '0;
      dvd_q  <= {job_i.sum, FRAC_W'(0)};
      div_q  <= job_i.divisor;
      row_q  <= job_i.row;
      col_q  <= job_i.col;
      last_q <= job_i.last;
    end else if (st_q == D_RUN) begin
      rem_q <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
    end
  end

  assign m_axis_tvalid = (st_q == D_HOLD);
  assign m_axis_tdata  = {PAD_W'(0), col_q, row_q, dvd_q[MEAN_W-1:0]};
  assign m_axis_tlast  = last_q;

  `MAG_ASSERT(a_rem_below, (st_q == D_RUN) |-> rem_q < div_q, "partial remainder not below divisor")
  `MAG_ASSERT(a_run_done, (st_q == D_RUN) && (cnt_q == CNT_W'(1)) |=> m_axis_tvalid, "divide did not finish on count")
  `MAG_ASSERT(a_start_run, start |=> (st_q == D_RUN) && (cnt_q == CNT_W'(DVD_W)), "divide did not start")
  `MAG_ASSERT(a_free_idle, !(m_axis_tvalid && job_ready_o), "divider free while result pending")

endmodule

// ===== sv/mean_abs_gradient_window_top.sv =====
// Top level of the sliding-window mean absolute gradient filter.
//
//  port group  | dir | transaction
//  cfg_*       | in  | register write: cfg_index_i selects, cfg_data_i carries value
//  s_axis_*    | in  | one grayscale pixel, raster order from top left
//  m_axis_*    | out | one window mean with its output grid position
//
// A pixel is handled as a line-store read, then a modify and write back; one that
// yields a result adds a hand-off state and a bit-serial divide.
// The divide runs alongside later pixels; the next result-producing pixel waits
// for the divider, which holds its result until m_axis_tready.
// Reset returns the configuration registers to their defaults; the line stores need no clearing.
// A configuration write restarts the frame at its top-left pixel.
`timescale 1ns / 1ps
module mean_abs_gradient_window_top
  import mag_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] mean_abs_diff, [25:16] out_row,
                                                 // [35:26] out_col, [39:36] zero
  output logic                   m_axis_tlast    // frame_last
);

  logic job_valid;
  logic job_ready;
  job_t job;

  assign cfg_ready_o = 1'b1;

  mag_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_i       (s_axis_tdata[PIX_W-1:0]),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  mag_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_ready_o   (job_ready),
    .job_i         (job),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
